/* rtl/core/adaptive_replacement_cache_policy_assert.svh */
// Assertion macros shared by the directory RTL.
`ifndef ADAPTIVE_REPLACEMENT_CACHE_POLICY_ASSERT_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_POLICY_ASSERT_SVH

// same-cycle check
`define ARC_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent now, consequent in the next cycle
`define ARC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/arc_pkg.sv */
// Types and fixed constants for the adaptive replacement cache directory.
package arc_pkg;
	localparam int unsigned CFG_W     = 7;
	localparam int unsigned OUTCOME_W = 3;
	localparam int unsigned EVP_W     = 32;
	localparam int unsigned TP_W      = 7;
	localparam int unsigned HIT_W     = 32;
	localparam int unsigned OUT_W     = 80;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [2:0] {
		OUT_T1_HIT = 3'd0,
		OUT_T2_HIT = 3'd1,
		OUT_B1_HIT = 3'd2,
		OUT_B2_HIT = 3'd3,
		OUT_MISS   = 3'd4
	} outcome_t;

	typedef enum logic [1:0] {
		LIST_T1 = 2'd0,
		LIST_T2 = 2'd1,
		LIST_B1 = 2'd2,
		LIST_B2 = 2'd3
	} list_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_UNLINK,
		CMD_PUSH,
		CMD_CLEAR
	} cmd_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_DIV,
		ST_ADAPT,
		ST_DROP,
		ST_REP_UNLINK,
		ST_REP_PUSH,
		ST_MV_UNLINK,
		ST_MV_PUSH,
		ST_INSERT,
		ST_FINISH
	} state_t;

	// control bits rippling along the cell row
	typedef struct packed {
		logic  hit;
		list_t list;
		logic  claim;
	} link_t;
endpackage

/* rtl/core/arc_cell.sv */
// One directory slot: page, list, rank within list, valid.
module arc_cell #(
	parameter int unsigned PAGE_BITS = 32,
	parameter int unsigned RANK_W    = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arc_pkg::cmd_op_t      cmd_op,
	input  arc_pkg::list_t        cmd_list,
	input  logic [RANK_W-1:0]     cmd_rank,
	input  logic [PAGE_BITS-1:0]  cmd_page,
	input  arc_pkg::link_t        ctl_in,
	input  logic [RANK_W-1:0]     rank_in,
	input  logic [PAGE_BITS-1:0]  page_in,
	output arc_pkg::link_t        ctl_out,
	output logic [RANK_W-1:0]     rank_out,
	output logic [PAGE_BITS-1:0]  page_out
);
	import arc_pkg::*;

	logic                 valid_q;
	list_t                list_q;
	logic [RANK_W-1:0]    rank_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 in_list, match, take, unlink_hit;

	assign in_list    = valid_q && (list_q == cmd_list);
	assign match      = valid_q && (page_q == cmd_page);
	assign unlink_hit = (cmd_op == CMD_UNLINK) && in_list && (rank_q == cmd_rank);
	// first free slot along the row takes a pushed word
	assign take       = (cmd_op == CMD_PUSH) && !valid_q && !ctl_in.claim;

	assign ctl_out.hit   = ctl_in.hit | match;
	assign ctl_out.list  = list_t'(ctl_in.list | (match ? list_q : LIST_T1));
	assign ctl_out.claim = ctl_in.claim | !valid_q;
	assign rank_out      = rank_in | (match ? rank_q : '0);
	assign page_out      = page_in | (unlink_hit ? page_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_op == CMD_CLEAR || unlink_hit) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_op == CMD_UNLINK && in_list && rank_q > cmd_rank) begin
			rank_q <= rank_q - 1'b1;
		end else if (cmd_op == CMD_PUSH && in_list) begin
			rank_q <= rank_q + 1'b1;
		end else if (take) begin
			rank_q <= '0;
		end
		if (take) begin
			list_q <= cmd_list;
			page_q <= cmd_page;
		end
	end
endmodule

/* rtl/core/arc_div.sv */
// Restoring divider, one quotient bit per cycle.
module arc_div #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q, quo_q, den_q, quo_d;
	logic [W:0]       sh;
	logic             ge;

	assign sh       = {rem_q, quo_q[W-1]};
	assign ge       = sh >= {1'b0, den_q};
	assign quo_d    = {quo_q[W-2:0], ge};
	// last step lands at the edge where done is high; quotient is valid after it
	assign done     = (cnt_q == CNT_W'(1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? W'(sh - {1'b0, den_q}) : sh[W-1:0];
			quo_q <= quo_d;
		end
	end
endmodule

/* rtl/core/adaptive_replacement_cache_policy.sv */
// Top level: request sequencer driving a row of directory cells.
//
//  channel | dir | handshake            | word
//  s       | in  | s_tvalid / s_tready  | page
//  m       | out | m_tvalid / m_tready  | outcome, evicted, target p, hit count
//  cfg     | in  | cfg_valid/cfg_ready  | cache_size
//
// Path per request after the IDLE state that takes the word: resident hit LOOK, DECIDE,
// MV_UNLINK, MV_PUSH, FINISH; miss LOOK, DECIDE, ghost drop, REPLACE if needed, INSERT,
// FINISH; ghost hit LOOK, DECIDE, DIV (bit-serial divider for p), ADAPT, REPLACE, the move.
// Each directory step (unlink, push) is a single broadcast over the cell row.
// Reset clears the cell valid bits at once; a cache_size write clears them with a CLEAR broadcast.
// A finished result sits in the output register; the next request is taken meanwhile,
// and the sequencer holds in its last state while that register is still full.
module adaptive_replacement_cache_policy #(
	parameter int unsigned MAX_ENTRIES = 64,
	parameter int unsigned PAGE_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [arc_pkg::CFG_W-1:0]           cfg_data,  // cache_size
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((PAGE_BITS+7)/8)*8-1:0]      s_tdata,   // page
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// outcome[2:0], evicted_valid[3], evicted_page[35:4], target_p[42:36], hit_count[74:43]
	output logic [arc_pkg::OUT_W-1:0]           m_tdata
);
	import arc_pkg::*;

	localparam int unsigned NSLOT  = 2 * MAX_ENTRIES;
	localparam int unsigned RANK_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int unsigned CW     = $clog2(NSLOT + 1);

	state_t               state_q, state_d;
	logic [CFG_W-1:0]     cfg_q;
	logic [CW-1:0]        c_eff;
	logic [CW-1:0]        cnt_q [4];
	logic [CW-1:0]        p_q;
	logic [HIT_W-1:0]     hits_q;
	logic [PAGE_BITS-1:0] pg_q;
	logic                 hit_q;
	list_t                hit_list_q;
	logic [RANK_W-1:0]    hit_rank_q;
	outcome_t             outcome_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	list_t                drop_list_q, rep_list_q;
	logic                 drop_ev_q, drop_rep_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	// cell row
	cmd_op_t              cmd_op;
	list_t                cmd_list;
	logic [RANK_W-1:0]    cmd_rank;
	logic [PAGE_BITS-1:0] cmd_page;
	link_t                ctl_chain  [NSLOT+1];
	logic [RANK_W-1:0]    rank_chain [NSLOT+1];
	logic [PAGE_BITS-1:0] page_chain [NSLOT+1];

	logic                 in_acc, cfg_acc, ghost, ghost_b2, out_free;
	logic                 rep_use_t1, rep_skip;
	list_t                rep_src;
	logic [CW:0]          l1_sum, two_c;
	logic [CW+1:0]        tot_sum;
	logic                 div_start, div_done;
	logic [CW-1:0]        div_a, div_b, div_q, d_val;
	logic [CW:0]          p_sum;
	logic [CW-1:0]        p_new;
	logic [63:0]          ev_wide;
	logic [31:0]          p_wide;
	logic [CW+1:0]        dir_total;
	logic                 res_hit_evict;

	assign ctl_chain[0]  = '0;
	assign rank_chain[0] = '0;
	assign page_chain[0] = '0;

	for (genvar i = 0; i < NSLOT; i++) begin : g_cell
		arc_cell #(.PAGE_BITS(PAGE_BITS), .RANK_W(RANK_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd_op   (cmd_op),
			.cmd_list (cmd_list),
			.cmd_rank (cmd_rank),
			.cmd_page (cmd_page),
			.ctl_in   (ctl_chain[i]),
			.rank_in  (rank_chain[i]),
			.page_in  (page_chain[i]),
			.ctl_out  (ctl_chain[i+1]),
			.rank_out (rank_chain[i+1]),
			.page_out (page_chain[i+1])
		);
	end

	arc_div #(.W(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		if (cfg_q == '0) begin
			c_eff = CW'(1);
		end else if (32'(cfg_q) > MAX_ENTRIES) begin
			c_eff = CW'(MAX_ENTRIES);
		end else begin
			c_eff = CW'(cfg_q);
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign ghost     = hit_q && (hit_list_q == LIST_B1 || hit_list_q == LIST_B2);
	assign ghost_b2  = hit_q && (hit_list_q == LIST_B2);

	assign l1_sum  = {1'b0, cnt_q[LIST_T1]} + {1'b0, cnt_q[LIST_B1]};
	assign tot_sum = {1'b0, l1_sum} + {2'b0, cnt_q[LIST_T2]} + {2'b0, cnt_q[LIST_B2]};
	assign two_c   = {c_eff, 1'b0};

	// REPLACE source list
	always_comb begin
		rep_use_t1 = (cnt_q[LIST_T1] != '0) &&
			((ghost_b2 && cnt_q[LIST_T1] == p_q) || cnt_q[LIST_T1] > p_q);
		rep_skip = 1'b0;
		if (!rep_use_t1 && cnt_q[LIST_T2] == '0) begin
			if (cnt_q[LIST_T1] == '0) begin
				rep_skip = 1'b1;
			end else begin
				rep_use_t1 = 1'b1;
			end
		end
		rep_src = rep_use_t1 ? LIST_T1 : LIST_T2;
	end

	// divider operands and p step
	assign div_start = (state_q == ST_DECIDE) && ghost;
	assign div_a     = (hit_list_q == LIST_B1) ? cnt_q[LIST_B2] : cnt_q[LIST_B1];
	assign div_b     = (hit_list_q == LIST_B1) ? cnt_q[LIST_B1] : cnt_q[LIST_B2];
	assign d_val     = (div_b == '0 || div_q == '0) ? CW'(1) : div_q;
	assign p_sum     = {1'b0, p_q} + {1'b0, d_val};

	always_comb begin
		if (hit_list_q == LIST_B1) begin
			p_new = (p_sum > {1'b0, c_eff}) ? c_eff : p_sum[CW-1:0];
		end else begin
			p_new = (p_q > d_val) ? CW'(p_q - d_val) : '0;
			if (p_new > c_eff) begin
				p_new = c_eff;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_LOOK;
			ST_LOOK:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (hit_q && !ghost) begin
					state_d = ST_MV_UNLINK;
				end else if (ghost) begin
					state_d = ST_DIV;
				end else if (l1_sum == {1'b0, c_eff}) begin
					state_d = ST_DROP;
				end else if (l1_sum < {1'b0, c_eff} && tot_sum >= {1'b0, two_c}) begin
					state_d = ST_DROP;
				end else if (l1_sum < {1'b0, c_eff} && tot_sum >= {2'b0, c_eff}) begin
					state_d = ST_REP_UNLINK;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_DIV:        if (div_done) state_d = ST_ADAPT;
			ST_ADAPT:      state_d = ST_REP_UNLINK;
			ST_DROP:       state_d = drop_rep_q ? ST_REP_UNLINK : ST_INSERT;
			ST_REP_UNLINK: begin
				if (!rep_skip) begin
					state_d = ST_REP_PUSH;
				end else begin
					state_d = ghost ? ST_MV_UNLINK : ST_INSERT;
				end
			end
			ST_REP_PUSH:   state_d = ghost ? ST_MV_UNLINK : ST_INSERT;
			ST_MV_UNLINK:  state_d = ST_MV_PUSH;
			ST_MV_PUSH:    state_d = ST_FINISH;
			ST_INSERT:     state_d = ST_FINISH;
			ST_FINISH:     if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// cell row command
	always_comb begin
		cmd_op   = CMD_NONE;
		cmd_list = LIST_T1;
		cmd_rank = '0;
		cmd_page = pg_q;
		unique case (state_q)
			ST_IDLE: if (cfg_acc) cmd_op = CMD_CLEAR;
			ST_DROP: begin
				cmd_list = drop_list_q;
				cmd_rank = RANK_W'(cnt_q[drop_list_q] - 1'b1);
				if (cnt_q[drop_list_q] != '0) cmd_op = CMD_UNLINK;
			end
			ST_REP_UNLINK: begin
				cmd_list = rep_src;
				cmd_rank = RANK_W'(cnt_q[rep_src] - 1'b1);
				if (!rep_skip) cmd_op = CMD_UNLINK;
			end
			ST_REP_PUSH: begin
				cmd_op   = CMD_PUSH;
				cmd_list = rep_list_q;
				cmd_page = ev_page_q;
			end
			ST_MV_UNLINK: begin
				cmd_op   = CMD_UNLINK;
				cmd_list = hit_list_q;
				cmd_rank = hit_rank_q;
			end
			ST_MV_PUSH: begin
				cmd_op   = CMD_PUSH;
				cmd_list = LIST_T2;
			end
			ST_INSERT: begin
				cmd_op   = CMD_PUSH;
				cmd_list = LIST_T1;
			end
			default: cmd_op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			p_q         <= '0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) cnt_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (m_tready && state_q != ST_FINISH) out_valid_q <= 1'b0;
			if (cfg_acc) begin
				cfg_q <= cfg_data;
				p_q   <= '0;
				for (int k = 0; k < 4; k++) cnt_q[k] <= '0;
			end
			case (state_q)
				ST_DECIDE: if (hit_q && !ghost && hits_q != '1) hits_q <= hits_q + 1'b1;
				ST_ADAPT:  p_q <= p_new;
				ST_DROP:   if (cnt_q[drop_list_q] != '0) begin
					cnt_q[drop_list_q] <= cnt_q[drop_list_q] - 1'b1;
				end
				ST_REP_UNLINK: if (!rep_skip) cnt_q[rep_src] <= cnt_q[rep_src] - 1'b1;
				ST_REP_PUSH:   if (ctl_chain[NSLOT].claim) begin
					cnt_q[rep_list_q] <= cnt_q[rep_list_q] + 1'b1;
				end
				ST_MV_UNLINK:  cnt_q[hit_list_q] <= cnt_q[hit_list_q] - 1'b1;
				ST_MV_PUSH:    if (ctl_chain[NSLOT].claim) begin
					cnt_q[LIST_T2] <= cnt_q[LIST_T2] + 1'b1;
				end
				ST_INSERT:     if (ctl_chain[NSLOT].claim) begin
					cnt_q[LIST_T1] <= cnt_q[LIST_T1] + 1'b1;
				end
				// a drained or empty output register takes the new word
				ST_FINISH:     if (out_free) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign ev_wide = 64'(ev_page_q);
	assign p_wide  = 32'(p_q);

	always_ff @(posedge clk) begin
		if (in_acc) pg_q <= s_tdata[PAGE_BITS-1:0];
		case (state_q)
			ST_LOOK: begin
				hit_q      <= ctl_chain[NSLOT].hit;
				hit_list_q <= ctl_chain[NSLOT].list;
				hit_rank_q <= rank_chain[NSLOT];
				ev_valid_q <= 1'b0;
				ev_page_q  <= '0;
			end
			ST_DECIDE: begin
				if (hit_q) begin
					outcome_q <= outcome_t'({1'b0, hit_list_q});
				end else begin
					outcome_q <= OUT_MISS;
				end
				// miss paths: drop a ghost LRU or evict the T1 LRU
				drop_ev_q   <= 1'b0;
				drop_rep_q  <= 1'b1;
				drop_list_q <= LIST_B2;
				if (l1_sum == {1'b0, c_eff}) begin
					if (cnt_q[LIST_T1] < c_eff) begin
						drop_list_q <= LIST_B1;
					end else begin
						drop_list_q <= LIST_T1;
						drop_ev_q   <= 1'b1;
						drop_rep_q  <= 1'b0;
					end
				end
			end
			ST_DROP: if (drop_ev_q && cnt_q[drop_list_q] != '0) begin
				ev_valid_q <= 1'b1;
				ev_page_q  <= page_chain[NSLOT];
			end
			ST_REP_UNLINK: if (!rep_skip) begin
				ev_valid_q <= 1'b1;
				ev_page_q  <= page_chain[NSLOT];
				rep_list_q <= list_t'({1'b1, rep_src[0]});
			end
			// the ghost hit entry shifts down when its own list gets a new front
			ST_REP_PUSH: if (ghost && hit_list_q == rep_list_q) begin
				hit_rank_q <= hit_rank_q + 1'b1;
			end
			ST_FINISH: if (out_free) begin
				out_data_q <= {5'b0, hits_q, p_wide[TP_W-1:0], ev_wide[EVP_W-1:0],
					ev_valid_q, outcome_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign dir_total = {2'b0, cnt_q[0]} + {2'b0, cnt_q[1]} + {2'b0, cnt_q[2]} +
		{2'b0, cnt_q[3]};
	assign res_hit_evict = out_valid_q && out_data_q[2] == 1'b0 && out_data_q[1] == 1'b0 &&
		out_data_q[3];

	`include "adaptive_replacement_cache_policy_assert.svh"

	`ARC_CHECK_NEXT(a_hits_monotone, 1'b1, hits_q >= $past(hits_q), "hit count went down")
	`ARC_CHECK(a_p_bounded, p_q <= c_eff, "target p above cache size")
	`ARC_CHECK(a_hit_no_evict, !res_hit_evict, "resident hit reported an eviction")
	`ARC_CHECK(a_dir_bound, dir_total <= (CW+2)'(NSLOT), "list counts exceed directory")
endmodule
